>>> design/jaumann_stress_rotation_defines.svh
// ----------------------------------------------------------------------------
// Jaumann stress rotation assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef JAUMANN_STRESS_ROTATION_DEFINES_SVH
`define JAUMANN_STRESS_ROTATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/jsr_pkg.sv
// ----------------------------------------------------------------------------
// Jaumann stress rotation package
// Fixed widths, component and product indexes, and the product operand and spin tables.
// ----------------------------------------------------------------------------
`default_nettype none

package jsr_pkg;

  localparam int NUM_COMP   = 6;
  localparam int NUM_SPIN   = 3;
  localparam int NUM_OPND   = 9;
  localparam int NUM_PROD   = 12;
  localparam int NUM_STAGES = 7;

  localparam int SPIN_W = 32;
  localparam int DT_W   = 32;
  localparam int WD_W   = 64;              // spin times time step, exact
  localparam int LIMB_W = 32;              // slice width for the partial products
  localparam int PP_W   = 2 * (LIMB_W + 1); // signed 33 x 33 partial product
  localparam int QW     = PP_W + LIMB_W;    // one operand slice times the whole of wd

  typedef logic [3:0] opnd_idx_t;
  typedef logic [2:0] comp_idx_t;
  typedef logic [1:0] spin_idx_t;

  // Tensor components, then the three normal differences.
  localparam opnd_idx_t C_XX = 4'd0;
  localparam opnd_idx_t C_YY = 4'd1;
  localparam opnd_idx_t C_ZZ = 4'd2;
  localparam opnd_idx_t C_XY = 4'd3;
  localparam opnd_idx_t C_XZ = 4'd4;
  localparam opnd_idx_t C_YZ = 4'd5;
  localparam opnd_idx_t D_XY = 4'd6;  // xx - yy
  localparam opnd_idx_t D_XZ = 4'd7;  // xx - zz
  localparam opnd_idx_t D_YZ = 4'd8;  // yy - zz

  // The same six components as indexes into per-component arrays.
  localparam comp_idx_t T_XX = 3'd0;
  localparam comp_idx_t T_YY = 3'd1;
  localparam comp_idx_t T_ZZ = 3'd2;
  localparam comp_idx_t T_XY = 3'd3;
  localparam comp_idx_t T_XZ = 3'd4;
  localparam comp_idx_t T_YZ = 3'd5;

  localparam spin_idx_t W_XY = 2'd0;
  localparam spin_idx_t W_XZ = 2'd1;
  localparam spin_idx_t W_YZ = 2'd2;

  // Products, each an operand times a scaled spin.
  localparam int PR_XY_W3  = 0;
  localparam int PR_XZ_W4  = 1;
  localparam int PR_YZ_W5  = 2;
  localparam int PR_DXY_W3 = 3;
  localparam int PR_XZ_W5  = 4;
  localparam int PR_YZ_W4  = 5;
  localparam int PR_DXZ_W4 = 6;
  localparam int PR_XY_W5  = 7;
  localparam int PR_YZ_W3  = 8;
  localparam int PR_DYZ_W5 = 9;
  localparam int PR_XY_W4  = 10;
  localparam int PR_XZ_W3  = 11;

  localparam opnd_idx_t PROD_OPND [NUM_PROD] = '{
    C_XY, C_XZ, C_YZ, D_XY, C_XZ, C_YZ, D_XZ, C_XY, C_YZ, D_YZ, C_XY, C_XZ
  };

  localparam spin_idx_t PROD_SPIN [NUM_PROD] = '{
    W_XY, W_XZ, W_YZ, W_XY, W_YZ, W_XZ, W_XZ, W_YZ, W_XY, W_YZ, W_XZ, W_XY
  };

endpackage

`default_nettype wire

>>> design/jaumann_stress_rotation.sv
// ----------------------------------------------------------------------------
// Jaumann stress rotation, one symmetric tensor per beat
// Throughput: one beat per cycle through the seven-stage multiply/sum pipeline,
// as long as m_axis_tready does not stall the output register.
// Reset (rst, synchronous): empties the pipeline and clears time_step to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jaumann_stress_rotation_defines.svh"

module jaumann_stress_rotation
  import jsr_pkg::*;
#(
  parameter int STRESS_WIDTH = 48,
  parameter int ROT_FRAC     = 40,
  localparam int IN_BITS     = NUM_COMP * STRESS_WIDTH + NUM_SPIN * SPIN_W,
  localparam int IN_W        = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = NUM_COMP * STRESS_WIDTH,
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Input beat.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: stress_xx, stress_yy, stress_zz, stress_xy,
  // stress_xz, stress_yz, spin_xy, spin_xz, spin_yz, zero fill.
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  // Result beat.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // Fields from bit 0 up: new_xx, new_yy, new_zz, new_xy, new_xz, new_yz,
  // zero fill.
  output logic [OUT_W-1:0]       m_axis_tdata,
  // Time step register write.
  input  wire logic              cfg_wr_en,
  input  wire logic [DT_W-1:0]   cfg_wr_data
);

  // Operand widths. The normal differences need one bit more than a
  // component. Operands are cut into 32-bit slices (the top slice signed),
  // and so is the 64-bit product of spin and time step, so every multiplier
  // in the design is a signed 33 x 33 unit.
  localparam int DW  = STRESS_WIDTH + 1;
  localparam int NC  = (DW + LIMB_W - 1) / LIMB_W;
  localparam int XW  = NC * LIMB_W;
  localparam int EW  = QW + LIMB_W * (NC - 1);
  localparam int PW  = DW + WD_W;   // exact operand times spin times dt
  localparam int IW  = PW + 3;      // exact sum of three products, or twice two
  localparam int RW  = IW + 1;      // room for the rounding bias

  localparam logic signed [RW-1:0] RND = RW'(1) <<< (ROT_FRAC - 1);
  localparam logic [STRESS_WIDTH-1:0] S_MAX = {1'b0, {(STRESS_WIDTH-1){1'b1}}};
  localparam logic [STRESS_WIDTH-1:0] S_MIN = {1'b1, {(STRESS_WIDTH-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration. The user must make writes only while no beat is in flight;
  // the block does not enforce it. The register feeds the first stage directly.
  // --------------------------------------------------------------------------
  logic [DT_W-1:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= '0;
    end else if (cfg_wr_en) begin
      time_step <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage reloads when it is empty or when the
  // stage after it reloads, so bubbles close up and the input keeps flowing
  // while a finished result waits in the output register, as long as a stage is empty.
  // valid[0] is the operand stage and valid[NUM_STAGES-1] the output register.
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] load;
  logic [NUM_STAGES-1:0] held;
  logic                  in_beat;
  logic                  out_beat;

  always_comb begin
    load[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  assign held          = valid & ~load;
  assign s_axis_tready = load[0];
  assign m_axis_tvalid = valid[NUM_STAGES-1];
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (load[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpack the beat, form the normal differences, and scale each
  // spin by the time step. Multiplying by dt first keeps the later products
  // exact: coef * s * w * dt equals coef * s * (w * dt) in integers.
  // --------------------------------------------------------------------------
  logic signed [STRESS_WIDTH-1:0] in_comp [NUM_COMP];
  logic signed [SPIN_W-1:0]       in_spin [NUM_SPIN];
  logic signed [DW-1:0]           opnd_nx [NUM_OPND];
  logic signed [WD_W-1:0]         wd_nx   [NUM_SPIN];

  for (genvar gc = 0; gc < NUM_COMP; gc++) begin : g_in_comp
    assign in_comp[gc] = s_axis_tdata[gc*STRESS_WIDTH +: STRESS_WIDTH];
    assign opnd_nx[gc] = DW'(in_comp[gc]);
  end

  assign opnd_nx[D_XY] = DW'(in_comp[T_XX]) - DW'(in_comp[T_YY]);
  assign opnd_nx[D_XZ] = DW'(in_comp[T_XX]) - DW'(in_comp[T_ZZ]);
  assign opnd_nx[D_YZ] = DW'(in_comp[T_YY]) - DW'(in_comp[T_ZZ]);

  for (genvar gs = 0; gs < NUM_SPIN; gs++) begin : g_in_spin
    logic signed [SPIN_W:0]     spin_x;
    logic signed [DT_W:0]       dt_x;
    logic signed [WD_W+1:0]     wd_full;
    assign in_spin[gs] = s_axis_tdata[NUM_COMP*STRESS_WIDTH + gs*SPIN_W +: SPIN_W];
    assign spin_x      = (SPIN_W + 1)'(in_spin[gs]);
    assign dt_x        = {1'b0, time_step};
    assign wd_full     = spin_x * dt_x;
    // |w * dt| < 2^63, so 64 bits hold it exactly.
    assign wd_nx[gs]   = wd_full[WD_W-1:0];
  end

  logic signed [STRESS_WIDTH-1:0] comp1 [NUM_COMP];
  logic signed [DW-1:0]           opnd1 [NUM_OPND];
  logic signed [WD_W-1:0]         wd1   [NUM_SPIN];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      comp1 <= in_comp;
      opnd1 <= opnd_nx;
      wd1   <= wd_nx;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: partial products. Each of the twelve products is split into
  // NC operand slices times two slices of the scaled spin.
  // --------------------------------------------------------------------------
  logic signed [PP_W-1:0] pp_nx [NUM_PROD][NC][2];

  for (genvar gp = 0; gp < NUM_PROD; gp++) begin : g_prod
    logic signed [XW-1:0]   a_ext;
    logic signed [WD_W-1:0] b_val;
    assign a_ext = XW'(opnd1[PROD_OPND[gp]]);
    assign b_val = wd1[PROD_SPIN[gp]];

    for (genvar gk = 0; gk < NC; gk++) begin : g_slice
      logic signed [LIMB_W:0] a_c;
      logic signed [LIMB_W:0] b_lo;
      logic signed [LIMB_W:0] b_hi;
      if (gk == NC - 1) begin : g_top
        assign a_c = {a_ext[XW-1], a_ext[gk*LIMB_W +: LIMB_W]};
      end else begin : g_low
        assign a_c = {1'b0, a_ext[gk*LIMB_W +: LIMB_W]};
      end
      assign b_lo = {1'b0, b_val[LIMB_W-1:0]};
      assign b_hi = {b_val[WD_W-1], b_val[WD_W-1:LIMB_W]};
      assign pp_nx[gp][gk][0] = a_c * b_lo;
      assign pp_nx[gp][gk][1] = a_c * b_hi;
    end
  end

  logic signed [STRESS_WIDTH-1:0] comp2 [NUM_COMP];
  logic signed [PP_W-1:0]         pp2   [NUM_PROD][NC][2];

  always_ff @(posedge clk) begin
    if (load[1]) begin
      comp2 <= comp1;
      pp2   <= pp_nx;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: join the two spin slices of each operand slice.
  // --------------------------------------------------------------------------
  logic signed [QW-1:0] q_nx [NUM_PROD][NC];

  always_comb begin
    for (int p = 0; p < NUM_PROD; p++) begin
      for (int k = 0; k < NC; k++) begin
        q_nx[p][k] = QW'(pp2[p][k][0]) + (QW'(pp2[p][k][1]) <<< LIMB_W);
      end
    end
  end

  logic signed [STRESS_WIDTH-1:0] comp3 [NUM_COMP];
  logic signed [QW-1:0]           q3    [NUM_PROD][NC];

  always_ff @(posedge clk) begin
    if (load[2]) begin
      comp3 <= comp2;
      q3    <= q_nx;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: join the operand slices into the full product. The true value
  // fits PW bits, so the wrap-around sum truncated to PW is exact.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] p_nx [NUM_PROD];

  always_comb begin
    logic signed [EW-1:0] acc;
    for (int p = 0; p < NUM_PROD; p++) begin
      acc = '0;
      for (int k = 0; k < NC; k++) begin
        acc = acc + (EW'(q3[p][k]) <<< (LIMB_W * k));
      end
      p_nx[p] = PW'(acc);
    end
  end

  logic signed [STRESS_WIDTH-1:0] comp4 [NUM_COMP];
  logic signed [PW-1:0]           p4    [NUM_PROD];

  always_ff @(posedge clk) begin
    if (load[3]) begin
      comp4 <= comp3;
      p4    <= p_nx;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: Jaumann increments, already multiplied by dt. The normal terms
  // carry the factor two; the shear terms use the normal differences.
  // --------------------------------------------------------------------------
  logic signed [IW-1:0] ip     [NUM_PROD];
  logic signed [IW-1:0] inc_nx [NUM_COMP];

  for (genvar gi = 0; gi < NUM_PROD; gi++) begin : g_ip
    assign ip[gi] = IW'(p4[gi]);
  end

  assign inc_nx[T_XX] = -((ip[PR_XY_W3] + ip[PR_XZ_W4]) <<< 1);
  assign inc_nx[T_YY] = (ip[PR_XY_W3] - ip[PR_YZ_W5]) <<< 1;
  assign inc_nx[T_ZZ] = (ip[PR_XZ_W4] + ip[PR_YZ_W5]) <<< 1;
  assign inc_nx[T_XY] = ip[PR_DXY_W3] - ip[PR_XZ_W5] - ip[PR_YZ_W4];
  assign inc_nx[T_XZ] = ip[PR_DXZ_W4] + ip[PR_XY_W5] - ip[PR_YZ_W3];
  assign inc_nx[T_YZ] = ip[PR_DYZ_W5] + ip[PR_XY_W4] + ip[PR_XZ_W3];

  logic signed [STRESS_WIDTH-1:0] comp5 [NUM_COMP];
  logic signed [IW-1:0]           inc5  [NUM_COMP];

  always_ff @(posedge clk) begin
    if (load[4]) begin
      comp5 <= comp4;
      inc5  <= inc_nx;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: round half up, drop the ROT_FRAC fraction bits, and add the
  // increment to the component.
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] sum_nx [NUM_COMP];

  always_comb begin
    logic signed [RW-1:0] biased;
    logic signed [RW-1:0] scaled;
    for (int c = 0; c < NUM_COMP; c++) begin
      biased    = RW'(inc5[c]) + RND;
      scaled    = biased >>> ROT_FRAC;
      sum_nx[c] = scaled + RW'(comp5[c]);
    end
  end

  logic signed [RW-1:0] sum6 [NUM_COMP];

  always_ff @(posedge clk) begin
    if (load[5]) begin
      sum6 <= sum_nx;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: saturate to the component range into the output register. A sum
  // is in range when every bit from the component's sign bit up agrees.
  // --------------------------------------------------------------------------
  logic [STRESS_WIDTH-1:0] res_nx [NUM_COMP];

  always_comb begin
    logic in_range;
    for (int c = 0; c < NUM_COMP; c++) begin
      in_range = (&sum6[c][RW-1:STRESS_WIDTH-1]) || !(|sum6[c][RW-1:STRESS_WIDTH-1]);
      if (in_range) begin
        res_nx[c] = sum6[c][STRESS_WIDTH-1:0];
      end else if (sum6[c][RW-1]) begin
        res_nx[c] = S_MIN;
      end else begin
        res_nx[c] = S_MAX;
      end
    end
  end

  logic [STRESS_WIDTH-1:0] res7 [NUM_COMP];

  always_ff @(posedge clk) begin
    if (load[6]) begin
      res7 <= res_nx;
    end
  end

  for (genvar go = 0; go < NUM_COMP; go++) begin : g_out
    assign m_axis_tdata[go*STRESS_WIDTH +: STRESS_WIDTH] = res7[go];
  end

  if (OUT_W > OUT_BITS) begin : g_out_pad
    assign m_axis_tdata[OUT_W-1:OUT_BITS] = '0;
  end

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------

  // A stage that holds a beat because the next one is full keeps it.
  `JSR_ASSERT_NEXT(a_no_drop, !rst, (valid & $past(held)) == $past(held), "stalled beat lost")

  // Beats in flight change only by accepted input and delivered output.
  `JSR_ASSERT_NEXT(a_conserve, !rst, $countones(valid) == $past($countones(valid)) + $past(in_beat) - $past(out_beat), "beat count broken")

  // Any empty slot in the pipeline lets a new beat in.
  `JSR_ASSERT_SAME(a_bubble_ready, !(&valid), s_axis_tready, "bubble but not ready")

endmodule

`default_nettype wire
